>>> design/eesp_pkg.sv
// ----------------------------------------------------------------------------
// eesp_pkg
// Shared widths, constants, command/status types and saturating arithmetic
// helpers for the energy-error step-size controller.
// ----------------------------------------------------------------------------
package eesp_pkg;

    localparam int W     = 48;             // word width
    localparam int F     = 32;             // fraction bits
    localparam int H     = W / 2;          // multiplier half width
    localparam int DN    = W + F;          // dividend width / divider steps
    localparam int DCW   = $clog2(DN);
    localparam int MCW   = 2;
    localparam int FIN_W = (W + F + 1 > 2 * W - F) ? W + F + 1 : 2 * W - F;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam longint unsigned ONE_Q = 64'd1 << F;

    localparam logic [W-1:0] MAXV     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV     = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_W    = W'(ONE_Q);
    localparam logic [W-1:0] TINY_Q   = W'((ONE_Q + 64'd500000000000) / 64'd1000000000000);
    localparam logic [W-1:0] MIN_STEP = W'((ONE_Q + 64'd500000) / 64'd1000000);
    localparam logic [W-1:0] DT_RESET = W'((ONE_Q + 64'd50) / 64'd100);
    localparam logic [W-2:0] STEP_RESET = (W-1)'((ONE_Q + 64'd500) / 64'd1000);

    typedef enum logic [2:0] {
        REG_GAIN_PROP     = 3'd0,
        REG_GAIN_INTEG    = 3'd1,
        REG_GAIN_DERIV    = 3'd2,
        REG_INTEG_FLOOR   = 3'd3,
        REG_INTEG_CEILING = 3'd4,
        REG_PID_INTERVAL  = 3'd5,
        REG_ENERGY_GOAL   = 3'd6,
        REG_START_STEP    = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_DIV_STEP,
        OP_ERR_FIN,
        OP_MUL_START,
        OP_MUL_STEP,
        OP_INTEG,
        OP_CLAMP,
        OP_DER_START,
        OP_DER_FIN,
        OP_CORR_SET,
        OP_CORR_ADD,
        OP_STEP
    } t_op;

    typedef enum logic [1:0] {
        MSEL_EDT,
        MSEL_P,
        MSEL_I,
        MSEL_D
    } t_msel;

    typedef struct packed {
        t_op   op;
        t_msel msel;
    } t_cmd;

    typedef struct packed {
        logic mul_last;
        logic div_last;
        logic dt_pos;
    } t_stat;

    typedef struct packed {
        logic [W-1:0] gain_prop;
        logic [W-1:0] gain_integ;
        logic [W-1:0] gain_deriv;
        logic [W-1:0] integ_floor;
        logic [W-1:0] integ_ceiling;
        logic [W-1:0] pid_interval;
        logic [W-1:0] energy_goal;
        logic [W-2:0] start_step;
        logic         step_load;
    } t_cfg;

    typedef struct packed {
        logic [W-1:0] v;
        logic         sat;
    } t_sres;

    function automatic logic [W-1:0] mag(input logic [W-1:0] a);
        return a[W-1] ? (~a + W'(1)) : a;
    endfunction

    function automatic t_sres sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        t_sres      r;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            r.v   = s[W] ? MINV : MAXV;
            r.sat = 1'b1;
        end else begin
            r.v   = s[W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic t_sres sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        t_sres      r;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            r.v   = s[W] ? MINV : MAXV;
            r.sat = 1'b1;
        end else begin
            r.v   = s[W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // magnitude plus sign back to a saturated two's complement word
    function automatic t_sres fin(input logic [FIN_W-1:0] m, input logic neg);
        logic [FIN_W-1:0] lim;
        t_sres            r;
        lim = neg ? FIN_W'(MINV) : FIN_W'(MAXV);
        if (m > lim) begin
            r.v   = neg ? MINV : MAXV;
            r.sat = 1'b1;
        end else begin
            r.v   = neg ? (~m[W-1:0] + W'(1)) : m[W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> design/eesp_if.sv
// ----------------------------------------------------------------------------
// eesp_in_if / eesp_out_if
// Valid/ready channels carrying measured energies in and step results out.
// ----------------------------------------------------------------------------
interface eesp_in_if import eesp_pkg::*; ();
    logic         valid;
    logic         ready;
    logic [W-1:0] energy_measured;

    modport source (output valid, output energy_measured, input ready);
    modport sink   (input valid, input energy_measured, output ready);
endinterface

interface eesp_out_if import eesp_pkg::*; ();
    logic         valid;
    logic         ready;
    logic [W-2:0] step_next;
    logic [W-1:0] error_normalized;
    logic         step_floored;
    logic         integ_clamped;
    logic         value_saturated;

    modport source (output valid, output step_next, output error_normalized,
                    output step_floored, output integ_clamped,
                    output value_saturated, input ready);
    modport sink   (input valid, input step_next, input error_normalized,
                    input step_floored, input integ_clamped,
                    input value_saturated, output ready);
endinterface

>>> design/eesp_ctrl.sv
// ----------------------------------------------------------------------------
// eesp_ctrl
// Sequencer: steps the datapath through division, PID terms and step update.
// ----------------------------------------------------------------------------
module eesp_ctrl import eesp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_DIV_E  = 20'h00002,
        S_ERR    = 20'h00004,
        S_MS_EDT = 20'h00008,
        S_MW_EDT = 20'h00010,
        S_INTEG  = 20'h00020,
        S_CLAMP  = 20'h00040,
        S_DS_D   = 20'h00080,
        S_DW_D   = 20'h00100,
        S_DERIV  = 20'h00200,
        S_MS_P   = 20'h00400,
        S_MW_P   = 20'h00800,
        S_CORR_P = 20'h01000,
        S_MS_I   = 20'h02000,
        S_MW_I   = 20'h04000,
        S_CORR_I = 20'h08000,
        S_MS_D   = 20'h10000,
        S_MW_D   = 20'h20000,
        S_CORR_D = 20'h40000,
        S_STEP   = 20'h80000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NONE;
        o_cmd.msel  = MSEL_EDT;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_START;
                    n_state  = S_DIV_E;
                end
            end
            S_DIV_E: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_stat.div_last) n_state = S_ERR;
            end
            S_ERR: begin
                o_cmd.op = OP_ERR_FIN;
                n_state  = i_stat.dt_pos ? S_MS_EDT : S_STEP;
            end
            S_MS_EDT: begin
                o_cmd.op   = OP_MUL_START;
                o_cmd.msel = MSEL_EDT;
                n_state    = S_MW_EDT;
            end
            S_MW_EDT: begin
                o_cmd.op = OP_MUL_STEP;
                if (i_stat.mul_last) n_state = S_INTEG;
            end
            S_INTEG: begin
                o_cmd.op = OP_INTEG;
                n_state  = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.op = OP_CLAMP;
                n_state  = S_DS_D;
            end
            S_DS_D: begin
                o_cmd.op = OP_DER_START;
                n_state  = S_DW_D;
            end
            S_DW_D: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_stat.div_last) n_state = S_DERIV;
            end
            S_DERIV: begin
                o_cmd.op = OP_DER_FIN;
                n_state  = S_MS_P;
            end
            S_MS_P: begin
                o_cmd.op   = OP_MUL_START;
                o_cmd.msel = MSEL_P;
                n_state    = S_MW_P;
            end
            S_MW_P: begin
                o_cmd.op = OP_MUL_STEP;
                if (i_stat.mul_last) n_state = S_CORR_P;
            end
            S_CORR_P: begin
                o_cmd.op = OP_CORR_SET;
                n_state  = S_MS_I;
            end
            S_MS_I: begin
                o_cmd.op   = OP_MUL_START;
                o_cmd.msel = MSEL_I;
                n_state    = S_MW_I;
            end
            S_MW_I: begin
                o_cmd.op = OP_MUL_STEP;
                if (i_stat.mul_last) n_state = S_CORR_I;
            end
            S_CORR_I: begin
                o_cmd.op = OP_CORR_ADD;
                n_state  = S_MS_D;
            end
            S_MS_D: begin
                o_cmd.op   = OP_MUL_START;
                o_cmd.msel = MSEL_D;
                n_state    = S_MW_D;
            end
            S_MW_D: begin
                o_cmd.op = OP_MUL_STEP;
                if (i_stat.mul_last) n_state = S_CORR_D;
            end
            S_CORR_D: begin
                o_cmd.op = OP_CORR_ADD;
                n_state  = S_STEP;
            end
            S_STEP: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_STEP;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> design/eesp_dp.sv
// ----------------------------------------------------------------------------
// eesp_dp
// Datapath: shared 24x24 multiply-accumulate, bit-serial restoring divider,
// PID state and the result register.
// ----------------------------------------------------------------------------
module eesp_dp import eesp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    input  t_cfg         i_cfg,
    input  logic [W-1:0] i_energy,
    output logic [W-2:0] o_step_next,
    output logic [W-1:0] o_error_normalized,
    output logic         o_step_floored,
    output logic         o_integ_clamped,
    output logic         o_value_saturated
);

    // PID state
    logic [W-1:0] r_integ, r_prior, r_step;
    // per-item working values
    logic [W-1:0] r_err, r_deriv, r_corr;
    logic         r_sat, r_clamped;
    // multiplier
    logic [W-1:0]   r_ma, r_mb;
    logic           r_mneg;
    logic [2*W-1:0] r_mprod;
    logic [MCW-1:0] r_mcnt;
    // divider
    logic [DN-1:0]  r_dn, r_dq;
    logic [W-1:0]   r_drem, r_dden;
    logic           r_dneg;
    logic [DCW-1:0] r_dcnt;
    // result register
    logic [W-2:0] r_o_step;
    logic [W-1:0] r_o_err;
    logic         r_o_floored, r_o_clamped, r_o_sat;

    logic [H-1:0]   m_ah, m_bh;
    logic [2*H-1:0] m_pp;
    logic [2*W-1:0] m_ppx, m_rnd;
    t_sres          mul_res, div_res;
    logic           d_round;
    logic [W:0]     d_rem2, d_diff;

    logic [W-1:0] s_scale, s_emag, s_gmag, s_norm;
    t_sres        s_diff;
    logic [W-1:0] m_a, m_b;
    t_sres        t_add, t_sub, t_step;
    logic [W-1:0] c_val;
    logic         c_hit;

    // partial product for the current quarter
    always_comb begin
        m_ah  = r_mcnt[1] ? r_ma[W-1:H] : r_ma[H-1:0];
        m_bh  = r_mcnt[0] ? r_mb[W-1:H] : r_mb[H-1:0];
        m_pp  = m_ah * m_bh;
        m_ppx = (2*W)'(m_pp);
        case (r_mcnt)
            2'd0:    m_ppx = m_ppx;
            2'd3:    m_ppx = m_ppx << W;
            default: m_ppx = m_ppx << H;
        endcase
        m_rnd   = r_mprod + ((2*W)'(1) << (F - 1));
        mul_res = fin(FIN_W'(m_rnd >> F), r_mneg);
    end

    // divider step and rounding
    always_comb begin
        d_rem2  = {r_drem, r_dn[DN-1]};
        d_diff  = d_rem2 - {1'b0, r_dden};
        d_round = (r_drem >= (r_dden - r_drem));
        div_res = fin(FIN_W'(r_dq) + FIN_W'(d_round), r_dneg);
    end

    // error scale from the incoming item
    always_comb begin
        s_emag  = mag(i_energy);
        s_gmag  = mag(i_cfg.energy_goal);
        s_scale = (s_gmag > s_emag) ? s_gmag : s_emag;
        s_norm  = (s_scale == '0 || s_scale < TINY_Q) ? ONE_W : s_scale;
        s_diff  = sat_sub(i_energy, i_cfg.energy_goal);
    end

    always_comb begin
        case (i_cmd.msel)
            MSEL_EDT: begin m_a = r_err;             m_b = i_cfg.pid_interval; end
            MSEL_P:   begin m_a = i_cfg.gain_prop;   m_b = r_err;              end
            MSEL_I:   begin m_a = i_cfg.gain_integ;  m_b = r_integ;            end
            MSEL_D:   begin m_a = i_cfg.gain_deriv;  m_b = r_deriv;            end
            default:  begin m_a = r_err;             m_b = i_cfg.pid_interval; end
        endcase
        t_add  = sat_add((i_cmd.op == OP_INTEG) ? r_integ : r_corr, mul_res.v);
        t_sub  = sat_sub(r_err, r_prior);
        t_step = sat_add(r_step, r_corr);
        c_val  = r_integ;
        c_hit  = 1'b0;
        if ($signed(c_val) < $signed(i_cfg.integ_floor)) begin
            c_val = i_cfg.integ_floor;
            c_hit = 1'b1;
        end
        if ($signed(c_val) > $signed(i_cfg.integ_ceiling)) begin
            c_val = i_cfg.integ_ceiling;
            c_hit = 1'b1;
        end
    end

    // PID state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prior <= '0;
            r_step  <= W'(STEP_RESET);
        end else begin
            if (i_cfg.step_load) r_step <= W'(i_cfg.start_step);
            case (i_cmd.op)
                OP_INTEG:     r_integ <= t_add.v;
                OP_CLAMP:     r_integ <= c_val;
                OP_DER_START: r_prior <= r_err;
                OP_STEP: begin
                    if ($signed(t_step.v) < $signed(MIN_STEP)) r_step <= MIN_STEP;
                    else r_step <= t_step.v;
                end
                default: ;
            endcase
        end
    end

    // working registers, multiplier, divider, result
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_START: begin
                r_sat     <= s_diff.sat;
                r_clamped <= 1'b0;
                r_corr    <= '0;
                r_dn      <= {mag(s_diff.v), {F{1'b0}}};
                r_dq      <= '0;
                r_drem    <= '0;
                r_dden    <= s_norm;
                r_dneg    <= s_diff.v[W-1];
                r_dcnt    <= '0;
            end
            OP_DIV_STEP: begin
                r_dn   <= r_dn << 1;
                r_dcnt <= r_dcnt + DCW'(1);
                if (!d_diff[W]) begin
                    r_drem <= d_diff[W-1:0];
                    r_dq   <= {r_dq[DN-2:0], 1'b1};
                end else begin
                    r_drem <= d_rem2[W-1:0];
                    r_dq   <= {r_dq[DN-2:0], 1'b0};
                end
            end
            OP_ERR_FIN: begin
                r_err <= div_res.v;
                r_sat <= r_sat | div_res.sat;
            end
            OP_MUL_START: begin
                r_ma    <= mag(m_a);
                r_mb    <= mag(m_b);
                r_mneg  <= m_a[W-1] ^ m_b[W-1];
                r_mprod <= '0;
                r_mcnt  <= '0;
            end
            OP_MUL_STEP: begin
                r_mprod <= r_mprod + m_ppx;
                r_mcnt  <= r_mcnt + MCW'(1);
            end
            OP_INTEG: r_sat <= r_sat | mul_res.sat | t_add.sat;
            OP_CLAMP: r_clamped <= c_hit;
            OP_DER_START: begin
                r_sat  <= r_sat | t_sub.sat;
                r_dn   <= {mag(t_sub.v), {F{1'b0}}};
                r_dq   <= '0;
                r_drem <= '0;
                r_dden <= i_cfg.pid_interval;
                r_dneg <= t_sub.v[W-1];
                r_dcnt <= '0;
            end
            OP_DER_FIN: begin
                r_deriv <= div_res.v;
                r_sat   <= r_sat | div_res.sat;
            end
            OP_CORR_SET: begin
                r_corr <= mul_res.v;
                r_sat  <= r_sat | mul_res.sat;
            end
            OP_CORR_ADD: begin
                r_corr <= t_add.v;
                r_sat  <= r_sat | mul_res.sat | t_add.sat;
            end
            OP_STEP: begin
                if ($signed(t_step.v) < $signed(MIN_STEP)) begin
                    r_o_step    <= MIN_STEP[W-2:0];
                    r_o_floored <= 1'b1;
                end else begin
                    r_o_step    <= t_step.v[W-2:0];
                    r_o_floored <= 1'b0;
                end
                r_o_err     <= r_err;
                r_o_clamped <= r_clamped;
                r_o_sat     <= r_sat | t_step.sat;
            end
            default: ;
        endcase
    end

    assign o_stat.mul_last = (r_mcnt == {MCW{1'b1}});
    assign o_stat.div_last = (r_dcnt == DCW'(DN - 1));
    assign o_stat.dt_pos   = !i_cfg.pid_interval[W-1] && (i_cfg.pid_interval != '0);

    assign o_step_next        = r_o_step;
    assign o_error_normalized = r_o_err;
    assign o_step_floored     = r_o_floored;
    assign o_integ_clamped    = r_o_clamped;
    assign o_value_saturated  = r_o_sat;

endmodule

>>> design/energy_error_step_size_pid.sv
// ----------------------------------------------------------------------------
// energy_error_step_size_pid
// Adaptive integrator step from the normalised energy error via a clamped PID.
// ----------------------------------------------------------------------------
// Sequence: when pid_interval is positive, an item takes two bit-serial
//   divisions and four multiplies; when it is not, it takes one division only.
//   A new item is accepted only after the previous one has finished and
//   its result has been stored in the output register.
// Reset (i_rst_n low, synchronous): registers to defaults, integral and
//   prior error cleared, kept step loaded with the start step default.
// ----------------------------------------------------------------------------
module energy_error_step_size_pid import eesp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    eesp_in_if.sink           i_in_ch,
    eesp_out_if.source        o_out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // configuration register file, 64-bit slots at 8*index
    logic [W-1:0] r_gain_prop, r_gain_integ, r_gain_deriv;
    logic [W-1:0] r_integ_floor, r_integ_ceiling, r_pid_interval, r_energy_goal;
    logic [W-2:0] r_start_step;

    logic  cfg_wr;
    t_reg  cfg_idx;
    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg'(paddr[ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop     <= '0;
            r_gain_integ    <= '0;
            r_gain_deriv    <= '0;
            r_integ_floor   <= MINV;
            r_integ_ceiling <= MAXV;
            r_pid_interval  <= DT_RESET;
            r_energy_goal   <= '0;
            r_start_step    <= STEP_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GAIN_PROP:     r_gain_prop     <= pwdata[W-1:0];
                REG_GAIN_INTEG:    r_gain_integ    <= pwdata[W-1:0];
                REG_GAIN_DERIV:    r_gain_deriv    <= pwdata[W-1:0];
                REG_INTEG_FLOOR:   r_integ_floor   <= pwdata[W-1:0];
                REG_INTEG_CEILING: r_integ_ceiling <= pwdata[W-1:0];
                REG_PID_INTERVAL:  r_pid_interval  <= pwdata[W-1:0];
                REG_ENERGY_GOAL:   r_energy_goal   <= pwdata[W-1:0];
                REG_START_STEP:    r_start_step    <= pwdata[W-2:0];
                default: ;
            endcase
        end
    end

    // read back, signed words sign-extended
    always_comb begin
        case (cfg_idx)
            REG_GAIN_PROP:     prdata = DATA_W'($signed(r_gain_prop));
            REG_GAIN_INTEG:    prdata = DATA_W'($signed(r_gain_integ));
            REG_GAIN_DERIV:    prdata = DATA_W'($signed(r_gain_deriv));
            REG_INTEG_FLOOR:   prdata = DATA_W'($signed(r_integ_floor));
            REG_INTEG_CEILING: prdata = DATA_W'($signed(r_integ_ceiling));
            REG_PID_INTERVAL:  prdata = DATA_W'($signed(r_pid_interval));
            REG_ENERGY_GOAL:   prdata = DATA_W'($signed(r_energy_goal));
            REG_START_STEP:    prdata = DATA_W'(r_start_step);
            default:           prdata = '0;
        endcase
    end

    // a start step write also reloads the kept step in the datapath
    always_comb begin
        cfg.gain_prop     = r_gain_prop;
        cfg.gain_integ    = r_gain_integ;
        cfg.gain_deriv    = r_gain_deriv;
        cfg.integ_floor   = r_integ_floor;
        cfg.integ_ceiling = r_integ_ceiling;
        cfg.pid_interval  = r_pid_interval;
        cfg.energy_goal   = r_energy_goal;
        cfg.start_step    = pwdata[W-2:0];
        cfg.step_load     = cfg_wr && (cfg_idx == REG_START_STEP);
    end

    // sequencer: owns the handshakes and the result valid flag
    eesp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // arithmetic, PID state and result register
    eesp_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg              (cfg),
        .i_energy           (i_in_ch.energy_measured),
        .o_step_next        (o_out_ch.step_next),
        .o_error_normalized (o_out_ch.error_normalized),
        .o_step_floored     (o_out_ch.step_floored),
        .o_integ_clamped    (o_out_ch.integ_clamped),
        .o_value_saturated  (o_out_ch.value_saturated)
    );

endmodule
